FILE: design/assert_macros.svh
// Assertion macros shared by the utf8 accent fold design.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef NO_ASSERTIONS
`define UAF_ASSERT_ALWAYS(lbl, expr) \
  lbl: assert property (@(posedge clk) disable iff (rst) (expr)) \
    else $error("assertion failed");
`define UAF_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");
`else
`define UAF_ASSERT_ALWAYS(lbl, expr)
`define UAF_ASSERT_NEXT(lbl, ante, cons)
`endif
`endif

FILE: design/uaf_pkg.sv
// Types, byte constants and decode functions for the utf8 accent fold unit.
package uaf_pkg;

  localparam int unsigned WinDepth = 3;
  localparam int unsigned BufDepth = 4;
  localparam int unsigned MaxRes   = 4;

  localparam logic [7:0] LeadMin   = 8'hC0;
  localparam logic [7:0] Mask2     = 8'hE0;
  localparam logic [7:0] Mask3     = 8'hF0;
  localparam logic [7:0] Mask4     = 8'hF8;
  localparam logic [7:0] Lead3     = 8'hE0;
  localparam logic [7:0] Lead4     = 8'hF0;
  localparam logic [7:0] LeadE2    = 8'hE2;
  localparam logic [7:0] LeadC2    = 8'hC2;
  localparam logic [7:0] LeadC3    = 8'hC3;
  localparam logic [7:0] Cont80    = 8'h80;
  localparam logic [7:0] DashLo    = 8'h90;
  localparam logic [7:0] DashHi    = 8'h95;
  localparam logic [7:0] NnbspB3   = 8'hAF;
  localparam logic [7:0] NbspB2    = 8'hA0;
  localparam logic [7:0] ContMax   = 8'hBF;
  localparam logic [7:0] AsciiDash = 8'h2D;
  localparam logic [7:0] AsciiSp   = 8'h20;
  localparam logic [4:0] Low5      = 5'h1F;
  localparam logic [5:0] Low6      = 6'h3F;
  localparam logic [10:0] CombLo   = 11'h300;
  localparam logic [10:0] CombHi   = 11'h36F;

  typedef struct packed {
    logic [7:0] in_byte;
    logic       end_of_string;
  } in_req_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       has_byte;
    logic       string_done;
  } out_res_t;

  typedef struct packed {
    logic [1:0] consume;
    logic       has;
    logic [7:0] ob;
  } decision_t;

  function automatic logic [2:0] seq_length(input logic [7:0] c);
    logic [2:0] len;
    len = 3'd1;
    if (c >= LeadMin) begin
      if ((c & Mask2) == LeadMin) len = 3'd2;
      else if ((c & Mask3) == Lead3) len = 3'd3;
      else if ((c & Mask4) == Lead4) len = 3'd4;
    end
    return len;
  endfunction

  function automatic logic [7:0] fold_char(input logic [5:0] idx);
    logic [7:0] f;
    unique case (idx)
      6'd0, 6'd1, 6'd2, 6'd3, 6'd4, 6'd5, 6'd6: f = "A";
      6'd7:                                    f = "C";
      6'd8, 6'd9, 6'd10, 6'd11:                f = "E";
      6'd12, 6'd13, 6'd14, 6'd15:              f = "I";
      6'd16:                                   f = "D";
      6'd17:                                   f = "N";
      6'd18, 6'd19, 6'd20, 6'd21, 6'd22, 6'd24: f = "O";
      6'd25, 6'd26, 6'd27, 6'd28:              f = "U";
      6'd29:                                   f = "Y";
      6'd30:                                   f = "T";
      6'd31:                                   f = "s";
      6'd32, 6'd33, 6'd34, 6'd35, 6'd36, 6'd37, 6'd38: f = "a";
      6'd39:                                   f = "c";
      6'd40, 6'd41, 6'd42, 6'd43:              f = "e";
      6'd44, 6'd45, 6'd46, 6'd47:              f = "i";
      6'd48:                                   f = "d";
      6'd49:                                   f = "n";
      6'd50, 6'd51, 6'd52, 6'd53, 6'd54, 6'd56: f = "o";
      6'd57, 6'd58, 6'd59, 6'd60:              f = "u";
      6'd61, 6'd63:                            f = "y";
      6'd62:                                   f = "t";
      default:                                 f = 8'h00;
    endcase
    return f;
  endfunction

  function automatic decision_t decide(input logic [7:0] c, input logic [7:0] p1,
                                       input logic [7:0] p2, input logic [2:0] len);
    decision_t d;
    logic [10:0] cp;
    logic [7:0] f;
    d.consume = 2'd1;
    d.has     = 1'b1;
    d.ob      = c;
    cp = {c[4:0] & Low5, p1[5:0] & Low6};
    f  = fold_char(p1[5:0]);
    if (len == 3'd3 && c == LeadE2 && p1 == Cont80 && p2 >= DashLo && p2 <= DashHi) begin
      d.ob = AsciiDash;
      d.consume = 2'd3;
    end else if (len == 3'd3 && c == LeadE2 && p1 == Cont80 && p2 == NnbspB3) begin
      d.ob = AsciiSp;
      d.consume = 2'd3;
    end else if (len == 3'd2 && c == LeadC2 && p1 == NbspB2) begin
      d.ob = AsciiSp;
      d.consume = 2'd2;
    end else if (len == 3'd2 && cp >= CombLo && cp <= CombHi) begin
      d.has = 1'b0;
      d.consume = 2'd2;
    end else if (len == 3'd2 && c == LeadC3 && p1 >= Cont80 && p1 <= ContMax
                 && f != 8'h00) begin
      d.ob = f;
      d.consume = 2'd2;
    end
    return d;
  endfunction

endpackage

FILE: design/uaf_stream_if.sv
// Valid/ready request channel carrying one packed payload.
interface uaf_stream_if #(parameter type payload_t = logic);
  logic     valid;
  logic     ready;
  payload_t payload;

  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

FILE: design/utf8_accent_fold_unit.sv
// Top level of the utf8 accent fold unit: streams UTF-8 bytes in, folded ASCII bytes out.
//
// ingress takes one byte of a UTF-8 string per request, with end_of_string on the
// final byte. egress gives result requests: a byte with has_byte set, or a bare end
// marker (has_byte clear) when a string ends with nothing left to send; string_done
// marks the last result of each string.
// Bytes of an incomplete multi-byte sequence wait in a window of up to three bytes
// and produce nothing until the sequence completes or the string ends.
// The first result of a request appears on egress the cycle after it is accepted.
// A request yields zero to four results, sent one per cycle while egress is ready,
// from a result register bank; the next request is taken in the cycle the last of
// them leaves, so with one result or fewer per request and egress ready the unit
// accepts a request every cycle. When egress stalls, the results hold and ingress
// stays low on ready until the bank can be refilled. Reset (rst, synchronous)
// empties the window and drops any results not yet taken.
module utf8_accent_fold_unit
  import uaf_pkg::*;
(
  input logic          clk,
  input logic          rst,
  uaf_stream_if.sink   ingress,
  uaf_stream_if.source egress
);

`include "assert_macros.svh"

  logic [7:0] win_bytes [WinDepth];
  logic [1:0] win_count;
  out_res_t   res [MaxRes];
  logic [2:0] res_count;

  out_res_t   scan_res [MaxRes];
  logic [2:0] scan_count;
  logic [7:0] win_bytes_next [WinDepth];
  logic [1:0] win_count_next;
  in_req_t    req;
  logic       accept;
  logic       drain;

  assign req = ingress.payload;

  uaf_scan u_scan (
    .win_bytes      (win_bytes),
    .win_count      (win_count),
    .req            (req),
    .res            (scan_res),
    .res_count      (scan_count),
    .win_bytes_next (win_bytes_next),
    .win_count_next (win_count_next)
  );

  assign egress.valid   = (res_count != 3'd0);
  assign egress.payload = res[0];
  assign drain          = egress.valid & egress.ready;
  assign ingress.ready  = (res_count == 3'd0) | ((res_count == 3'd1) & egress.ready);
  assign accept         = ingress.valid & ingress.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      win_count <= 2'd0;
      res_count <= 3'd0;
    end else if (accept) begin
      win_count <= win_count_next;
      res_count <= scan_count;
    end else if (drain) begin
      res_count <= res_count - 3'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      win_bytes <= win_bytes_next;
      res       <= scan_res;
    end else if (drain) begin
      for (int i = 0; i < MaxRes - 1; i++) res[i] <= res[i + 1];
    end
  end

  `UAF_ASSERT_ALWAYS(a_res_bound, res_count <= 3'd4)
  `UAF_ASSERT_ALWAYS(a_accept_empty, !accept || res_count == 3'd0 || drain)
  `UAF_ASSERT_NEXT(a_end_clears_win, accept && req.end_of_string, win_count == 2'd0)
  `UAF_ASSERT_NEXT(a_end_has_result, accept && req.end_of_string, res_count != 3'd0)

endmodule

FILE: design/uaf_scan.sv
// Window scan: decodes pending bytes plus one new byte into results and the next window.
module uaf_scan
  import uaf_pkg::*;
(
  input  logic [7:0] win_bytes [WinDepth],
  input  logic [1:0] win_count,
  input  in_req_t    req,
  output out_res_t   res [MaxRes],
  output logic [2:0] res_count,
  output logic [7:0] win_bytes_next [WinDepth],
  output logic [1:0] win_count_next
);

  logic [7:0] buf_b [BufDepth];
  logic [2:0] n;
  logic [2:0] pos;
  logic [2:0] nout;
  logic [2:0] avail;
  logic [2:0] len;
  logic [2:0] rem;
  logic [1:0] last;
  logic       run;
  logic [7:0] c;
  decision_t  d;

  always_comb begin
    for (int i = 0; i < BufDepth; i++) begin
      if (i < int'(win_count)) buf_b[i] = win_bytes[i];
      else if (i == int'(win_count)) buf_b[i] = req.in_byte;
      else buf_b[i] = 8'h00;
    end
    n    = {1'b0, win_count} + 3'd1;
    pos  = 3'd0;
    nout = 3'd0;
    run  = 1'b1;
    for (int i = 0; i < MaxRes; i++) res[i] = '0;

    for (int k = 0; k < BufDepth; k++) begin
      c     = buf_b[pos[1:0]];
      len   = seq_length(c);
      avail = n - pos;
      d     = decide(c, buf_b[2'(pos + 3'd1)], buf_b[2'(pos + 3'd2)], len);
      if (run && pos < n) begin
        if (len > avail) begin
          if (!req.end_of_string) begin
            run = 1'b0;
          end else begin
            res[nout[1:0]] = '{out_byte: c, has_byte: 1'b1, string_done: 1'b0};
            nout = nout + 3'd1;
            pos  = pos + 3'd1;
          end
        end else begin
          if (d.has) begin
            res[nout[1:0]] = '{out_byte: d.ob, has_byte: 1'b1, string_done: 1'b0};
            nout = nout + 3'd1;
          end
          pos = pos + {1'b0, d.consume};
        end
      end
    end

    last = 2'(nout - 3'd1);
    if (req.end_of_string) begin
      if (nout == 3'd0) begin
        res[0] = '{out_byte: 8'h00, has_byte: 1'b0, string_done: 1'b1};
        nout = 3'd1;
      end else begin
        res[last].string_done = 1'b1;
      end
    end
    res_count = nout;

    rem = n - pos;
    for (int i = 0; i < WinDepth; i++) begin
      win_bytes_next[i] = buf_b[2'(pos + 3'(i))];
    end
    win_count_next = req.end_of_string ? 2'd0 : rem[1:0];
  end

endmodule
